FILE: rtl/rps_pkg.sv
// Shared constants and types for the random permutation shuffle unit.
// No dependencies; imported by every module of the block.
package rps_pkg;

    localparam int MAX_LENGTH_DEF = 1024;   // default table depth
    localparam int LEN_W          = 11;     // perm_length register width
    localparam int LEN_RESET      = 1024;   // perm_length after reset
    localparam int WORD_W         = 32;     // random word width
    localparam int POS_W          = 10;     // position / perm_value width
    localparam int OUT_DATA_W     = ((2 * POS_W + 7) / 8) * 8;
    localparam int DIV_BITS       = 2;      // quotient bits per divider cycle
    localparam int DIV_STEPS      = WORD_W / DIV_BITS;
    localparam int TAG_W          = 8;      // run tag width in the table

    typedef enum logic [2:0] {
        S_IDLE,
        S_DIV,
        S_RD_I,
        S_RD_J,
        S_WR_J,
        S_WR_I
    } t_state;

endpackage

FILE: rtl/rps_divider.sv
// Iterative remainder unit: 32-bit word modulo an 11-bit span, two bits a cycle.
// Depends on rps_pkg.
module rps_divider (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    input  logic [rps_pkg::WORD_W-1:0] i_dividend,
    input  logic [rps_pkg::LEN_W-1:0]  i_divisor,
    output logic                      o_done,
    output logic [rps_pkg::LEN_W-1:0]  o_rem
);
    import rps_pkg::*;

    localparam int CNT_W = $clog2(DIV_STEPS);

    logic              r_busy;
    logic              r_done;
    logic [CNT_W-1:0]  r_cnt;
    logic [WORD_W-1:0] r_q;
    logic [LEN_W-1:0]  r_rem;
    logic [LEN_W-1:0]  r_div;
    logic [LEN_W-1:0]  n_rem;
    logic [LEN_W-1:0]  part;
    logic [LEN_W:0]    trial;

    // restoring steps, MSB first
    always_comb begin
        part  = r_rem;
        trial = '0;
        for (int k = 0; k < DIV_BITS; k++) begin
            trial = {part, r_q[WORD_W-1-k]};
            if (trial >= {1'b0, r_div}) begin
                trial = trial - {1'b0, r_div};
            end
            part = trial[LEN_W-1:0];
        end
        n_rem = part;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + CNT_W'(1);
                if (r_cnt == CNT_W'(DIV_STEPS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q   <= i_dividend;
            r_rem <= '0;
            r_div <= i_divisor;
        end else if (r_busy) begin
            r_q   <= r_q << DIV_BITS;
            r_rem <= n_rem;
        end
    end

    assign o_done = r_done;
    assign o_rem  = r_rem;

endmodule

FILE: rtl/rps_table.sv
// Permutation table: one RAM of {run tag, value}, run tag counter, clearing pass.
// An entry whose tag differs from the current run reads as its own index.
// Depends on rps_pkg.
module rps_table #(
    parameter int MAX_LENGTH = rps_pkg::MAX_LENGTH_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_next_run,
    input  logic                          i_rd_en,
    input  logic [$clog2(MAX_LENGTH)-1:0] i_rd_addr,
    output logic [$clog2(MAX_LENGTH)-1:0] o_rd_data,
    input  logic                          i_wr_en,
    input  logic [$clog2(MAX_LENGTH)-1:0] i_wr_addr,
    input  logic [$clog2(MAX_LENGTH)-1:0] i_wr_data,
    output logic                          o_busy
);
    import rps_pkg::*;

    localparam int IDX_W = $clog2(MAX_LENGTH);
    localparam int ENT_W = TAG_W + IDX_W;

    logic [ENT_W-1:0] mem [MAX_LENGTH];

    logic [TAG_W-1:0] r_epoch;
    logic             r_clr_busy;
    logic [IDX_W-1:0] r_clr_addr;
    logic [ENT_W-1:0] r_q;
    logic [IDX_W-1:0] r_rd_addr;

    logic             we;
    logic [IDX_W-1:0] waddr;
    logic [ENT_W-1:0] wdata;

    // clearing pass owns the write port while it runs
    always_comb begin
        if (r_clr_busy) begin
            we    = 1'b1;
            waddr = r_clr_addr;
            wdata = '0;
        end else begin
            we    = i_wr_en;
            waddr = i_wr_addr;
            wdata = {r_epoch, i_wr_data};
        end
    end

    always_ff @(posedge i_clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_q       <= mem[i_rd_addr];
            r_rd_addr <= i_rd_addr;
        end
    end

    // tag zero is reserved for cleared entries
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_epoch    <= TAG_W'(1);
            r_clr_busy <= 1'b1;
            r_clr_addr <= '0;
        end else begin
            if (r_clr_busy) begin
                r_clr_addr <= r_clr_addr + IDX_W'(1);
                if (r_clr_addr == IDX_W'(MAX_LENGTH - 1)) begin
                    r_clr_busy <= 1'b0;
                end
            end
            if (i_next_run) begin
                if (r_epoch == '1) begin
                    r_epoch    <= TAG_W'(1);
                    r_clr_busy <= 1'b1;
                    r_clr_addr <= '0;
                end else begin
                    r_epoch <= r_epoch + TAG_W'(1);
                end
            end
        end
    end

    assign o_rd_data = (r_q[ENT_W-1:IDX_W] == r_epoch) ? r_q[IDX_W-1:0] : r_rd_addr;
    assign o_busy    = r_clr_busy;

endmodule

FILE: rtl/random_permutation_shuffle_unit.sv
// Random permutation shuffle unit (forward Fisher-Yates), top level.
// Channels: s_axis carries one 32-bit random word per transfer, one per step.
//   m_axis returns one transfer per step: position i and the final value at i,
//   with tlast on the last position of the permutation.
// Config: i_cfg_we / i_cfg_wdata write perm_length (0 acts as 1, values above
//   MAX_LENGTH saturate). Write only while no step is in flight.
// Per step: j = i + (word mod (length - i)); entries i and j swap, entry i emits.
// Path: each input transfer runs through the iterative remainder unit
//   (two quotient bits a cycle), then the read i, read j, write j and
//   write i states on the single-port-pair table RAM, then the output register.
// Overlap: one step is in flight at a time; no word is taken mid-step.
// Stall: the result sits in an output register. The next word is accepted
//   while it waits; that step then holds in its final write state, rewriting
//   entry i, until the register frees up.
// Reset: a clearing pass writes every table entry with s_axis_tready low.
//   The same pass repeats once every 255 runs when the run tag wraps.
//   perm_length resets to 1024 and the step counter to zero.
module random_permutation_shuffle_unit #(
    parameter int MAX_LENGTH = rps_pkg::MAX_LENGTH_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [rps_pkg::LEN_W-1:0]      i_cfg_wdata,     // perm_length
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [rps_pkg::WORD_W-1:0]     s_axis_tdata,    // [31:0] random_word
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    output logic [rps_pkg::OUT_DATA_W-1:0] m_axis_tdata,    // [9:0] position,
                                                            // [19:10] perm_value, rest 0
    output logic                          m_axis_tlast      // last
);
    import rps_pkg::*;

    localparam int IDX_W   = $clog2(MAX_LENGTH);
    localparam int CW      = (IDX_W > LEN_W) ? IDX_W : LEN_W;
    localparam int LEN_MAX = 2 ** LEN_W - 1;
    localparam int LEN_CAP = (MAX_LENGTH > LEN_MAX) ? LEN_MAX : MAX_LENGTH;

    t_state           r_state;
    t_state           n_state;
    logic [LEN_W-1:0] r_len;
    logic [IDX_W-1:0] r_step;
    logic [IDX_W-1:0] r_i;
    logic [IDX_W-1:0] r_j;
    logic             r_last;
    logic [IDX_W-1:0] r_vi;
    logic [IDX_W-1:0] r_vj;
    logic             r_out_valid;
    logic [POS_W-1:0] r_out_pos;
    logic [POS_W-1:0] r_out_val;
    logic             r_out_last;

    logic [LEN_W-1:0] eff_len;
    logic [CW-1:0]    len_ext;
    logic             abandon;
    logic [IDX_W-1:0] cur_i;
    logic [LEN_W-1:0] span;
    logic             is_last;
    logic             accept;
    logic             out_free;
    logic             div_done;
    logic [LEN_W-1:0] div_rem;
    logic [IDX_W-1:0] j_next;

    logic             tbl_busy;
    logic             tbl_rd_en;
    logic [IDX_W-1:0] tbl_rd_addr;
    logic [IDX_W-1:0] tbl_rd_data;
    logic             tbl_wr_en;
    logic [IDX_W-1:0] tbl_wr_addr;
    logic [IDX_W-1:0] tbl_wr_data;
    logic             next_run;
    logic             load_out;

    // effective length: zero acts as one, saturate at table depth
    always_comb begin
        if (r_len == '0) begin
            eff_len = LEN_W'(1);
        end else if (r_len > LEN_W'(LEN_CAP)) begin
            eff_len = LEN_W'(LEN_CAP);
        end else begin
            eff_len = r_len;
        end
    end

    assign len_ext  = CW'(eff_len);
    // a shortened length leaves the step past the end: restart at step zero
    assign abandon  = CW'(r_step) >= len_ext;
    assign cur_i    = abandon ? '0 : r_step;
    assign span     = LEN_W'(len_ext - CW'(cur_i));
    assign is_last  = CW'(cur_i) == (len_ext - CW'(1));
    assign accept   = s_axis_tvalid & s_axis_tready;
    assign out_free = !r_out_valid | m_axis_tready;
    assign j_next   = IDX_W'(CW'(r_i) + CW'(div_rem));

    assign s_axis_tready = (r_state == S_IDLE) & !tbl_busy;

    rps_divider u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (accept),
        .i_dividend (s_axis_tdata),
        .i_divisor  (span),
        .o_done     (div_done),
        .o_rem      (div_rem)
    );

    rps_table #(
        .MAX_LENGTH (MAX_LENGTH)
    ) u_table (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_next_run (next_run),
        .i_rd_en    (tbl_rd_en),
        .i_rd_addr  (tbl_rd_addr),
        .o_rd_data  (tbl_rd_data),
        .i_wr_en    (tbl_wr_en),
        .i_wr_addr  (tbl_wr_addr),
        .i_wr_data  (tbl_wr_data),
        .o_busy     (tbl_busy)
    );

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (accept) n_state = S_DIV;
            end
            S_DIV: begin
                if (div_done) n_state = S_RD_I;
            end
            S_RD_I: begin
                if (!tbl_busy) n_state = S_RD_J;   // wait out a clearing pass
            end
            S_RD_J: begin
                n_state = S_WR_J;
            end
            S_WR_J: begin
                n_state = S_WR_I;
            end
            S_WR_I: begin
                if (out_free) n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // table and output control
    always_comb begin
        tbl_rd_en   = 1'b0;
        tbl_rd_addr = r_i;
        tbl_wr_en   = 1'b0;
        tbl_wr_addr = r_j;
        tbl_wr_data = r_vi;
        load_out    = 1'b0;
        next_run    = 1'b0;
        case (r_state)
            S_IDLE: begin
                next_run = accept & abandon;
            end
            S_RD_I: begin
                tbl_rd_en = !tbl_busy;
            end
            S_RD_J: begin
                tbl_rd_en   = 1'b1;
                tbl_rd_addr = r_j;
            end
            S_WR_J: begin
                tbl_wr_en = 1'b1;
            end
            S_WR_I: begin
                // rewriting i while stalled is harmless
                tbl_wr_en   = 1'b1;
                tbl_wr_addr = r_i;
                tbl_wr_data = r_vj;
                load_out    = out_free;
                next_run    = out_free & r_last;
            end
            default: begin
                tbl_rd_en = 1'b0;
            end
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_len       <= LEN_W'(LEN_RESET);
            r_step      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                r_len <= i_cfg_wdata;
            end
            if (accept) begin
                r_step <= cur_i;
            end else if (load_out) begin
                r_step <= r_last ? '0 : r_i + IDX_W'(1);
            end
            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // step payload
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_i    <= cur_i;
            r_last <= is_last;
        end
        if (r_state == S_DIV && div_done) begin
            r_j <= j_next;
        end
        if (r_state == S_RD_J) begin
            r_vi <= tbl_rd_data;
        end
        if (r_state == S_WR_J) begin
            r_vj <= tbl_rd_data;   // read before j is written: i == j still works
        end
        if (load_out) begin
            r_out_pos  <= POS_W'(r_i);
            r_out_val  <= POS_W'(r_vj);
            r_out_last <= r_last;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = OUT_DATA_W'({r_out_val, r_out_pos});
    assign m_axis_tlast  = r_out_last;

    // swap partner always lies inside the run
    a_j_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RD_J) |-> (CW'(r_j) < len_ext) && (r_j >= r_i))
        else $error("swap index out of range");

    // a last result leaves the step counter at the start of a new run
    a_last_restarts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tlast) |-> (r_step == '0))
        else $error("step counter not cleared after last position");

    // a result is loaded only when the output register can take it
    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |-> !load_out)
        else $error("result overwrote a pending transfer");

    // table is never read or written by the step sequencer during a clearing pass
    a_no_write_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        tbl_busy |-> !tbl_wr_en && !tbl_rd_en)
        else $error("table access during clearing pass");

endmodule

FILE: dv/tb_top.sv
// Self-checking testbench for random_permutation_shuffle_unit (Fisher-Yates shuffle).
// Predicts every output transfer from its own shuffle model; depends on rps_pkg and the RTL.
`timescale 1ns / 100ps

module tb_top;
    import rps_pkg::*;

    localparam int CLK_HALF      = 4;     // 8 ns period
    localparam int SETTLE_CYCLES = 30;    // margin past the latency of one step
    localparam int STALL_LIMIT   = 8000;  // must outlast a clearing pass, plus margin
    localparam int RANDOM_ITEMS  = 330;
    localparam int MAX_REPORTS   = 10;

    typedef enum logic [1:0] {
        TRAFFIC_FREE,
        TRAFFIC_SRC_GAPS,
        TRAFFIC_SINK_STALLS,
        TRAFFIC_BOTH
    } t_traffic;

    // One finalized entry as it leaves the block.
    typedef struct packed {
        logic             last;
        logic [POS_W-1:0] value;
        logic [POS_W-1:0] position;
    } t_perm_out;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [LEN_W-1:0]      i_cfg_wdata;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [WORD_W-1:0]     s_axis_tdata;     // [31:0] random_word
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    logic [OUT_DATA_W-1:0] m_axis_tdata;     // [9:0] position, [19:10] perm_value, rest 0
    logic                  m_axis_tlast;     // last

    random_permutation_shuffle_unit #(
        .MAX_LENGTH (MAX_LENGTH_DEF)
    ) u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    // ------------------------------------------------------------------
    // Shuffle model state: table, written marks, step counter, length reg
    // ------------------------------------------------------------------
    logic [POS_W-1:0] shuf_table  [MAX_LENGTH_DEF];
    bit               shuf_marked [MAX_LENGTH_DEF] = '{default: 1'b0};
    int unsigned      shuf_step = 0;
    logic [LEN_W-1:0] shuf_len  = LEN_W'(LEN_RESET);

    t_perm_out   perm_expect_q[$];
    int unsigned mismatch_cnt = 0;
    int unsigned src_idle_pct = 0;
    int unsigned snk_stall_pct = 0;

    // 0 acts as 1, anything above the table depth saturates
    function automatic int unsigned effective_len(input logic [LEN_W-1:0] len);
        if (len == '0) return 1;
        if (len > MAX_LENGTH_DEF) return MAX_LENGTH_DEF;
        return int'(len);
    endfunction

    // One forward Fisher-Yates step: swap i with i + word mod (n - i), emit entry i.
    function automatic t_perm_out shuffle_step(input logic [WORD_W-1:0] word);
        int unsigned n;
        int unsigned i;
        int unsigned j;
        logic [POS_W-1:0] vi;
        logic [POS_W-1:0] vj;
        t_perm_out res;
        n = effective_len(shuf_len);
        // length shrank below the current step: abandon and restart
        if (shuf_step >= n) begin
            shuf_marked = '{default: 1'b0};
            shuf_step   = 0;
        end
        i  = shuf_step;
        j  = i + (word % (n - i));
        // never-written entries read as their own index
        vi = shuf_marked[i] ? shuf_table[i] : POS_W'(i);
        vj = shuf_marked[j] ? shuf_table[j] : POS_W'(j);
        shuf_table[j]  = vi;
        shuf_marked[j] = 1'b1;
        shuf_table[i]  = vj;
        shuf_marked[i] = 1'b1;
        res.position = POS_W'(i);
        res.value    = vj;
        res.last     = (i == n - 1);
        if (res.last) begin
            shuf_marked = '{default: 1'b0};
            shuf_step   = 0;
        end else begin
            shuf_step = i + 1;
        end
        return res;
    endfunction

    function automatic void note_error(input string msg);
        mismatch_cnt++;
        if (mismatch_cnt <= MAX_REPORTS) $display("ERROR @%0t: %s", $realtime, msg);
    endfunction

    function automatic void set_traffic(input t_traffic mode);
        case (mode)
            TRAFFIC_FREE: begin
                src_idle_pct  = 0;
                snk_stall_pct = 0;
            end
            TRAFFIC_SRC_GAPS: begin
                src_idle_pct  = 57;
                snk_stall_pct = 0;
            end
            TRAFFIC_SINK_STALLS: begin
                src_idle_pct  = 0;
                snk_stall_pct = 57;
            end
            default: begin
                src_idle_pct  = 12;
                snk_stall_pct = 12;
            end
        endcase
    endfunction

    // Mostly uniform words, with the all-zero and all-one words mixed in.
    function automatic logic [WORD_W-1:0] pick_word();
        int unsigned r;
        r = $urandom_range(99);
        if (r < 5) return '0;
        if (r < 10) return '1;
        return $urandom;
    endfunction

    // ------------------------------------------------------------------
    // Clock and sink-side ready
    // ------------------------------------------------------------------
    initial begin
        i_clk = 1'b0;
        forever #CLK_HALF i_clk = ~i_clk;
    end

    initial begin
        m_axis_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            m_axis_tready = ($urandom_range(99) >= snk_stall_pct);
        end
    end

    // ------------------------------------------------------------------
    // Result check: every output transfer against the oldest prediction
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin : result_check
        t_perm_out want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (perm_expect_q.size() == 0) begin
                note_error($sformatf("unexpected transfer pos=%0d value=%0d last=%0b",
                                     m_axis_tdata[POS_W-1:0],
                                     m_axis_tdata[2*POS_W-1:POS_W], m_axis_tlast));
            end else begin
                want = perm_expect_q.pop_front();
                if (m_axis_tdata[POS_W-1:0] !== want.position ||
                    m_axis_tdata[2*POS_W-1:POS_W] !== want.value ||
                    m_axis_tlast !== want.last ||
                    m_axis_tdata[OUT_DATA_W-1:2*POS_W] !== '0) begin
                    note_error($sformatf(
                        "exp pos=%0d value=%0d last=%0b, got pos=%0d value=%0d last=%0b pad=%0h",
                        want.position, want.value, want.last,
                        m_axis_tdata[POS_W-1:0], m_axis_tdata[2*POS_W-1:POS_W],
                        m_axis_tlast, m_axis_tdata[OUT_DATA_W-1:2*POS_W]));
                end
            end
        end
    end

    // Watchdog: ends the run when no transfer happens on either side for too long.
    initial begin : watchdog
        int unsigned quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < STALL_LIMIT) begin
            @(posedge i_clk);
            if (!i_rst_n || (s_axis_tvalid && s_axis_tready) ||
                (m_axis_tvalid && m_axis_tready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("random_permutation_shuffle_unit: mismatch");
        $finish;
    end

    // ------------------------------------------------------------------
    // Shared drivers (all called and returning at a falling edge)
    // ------------------------------------------------------------------
    task automatic send_word(input logic [WORD_W-1:0] word);
        while ($urandom_range(99) < src_idle_pct) begin
            s_axis_tvalid = 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tdata  = word;
        do @(posedge i_clk); while (!s_axis_tready);
        perm_expect_q.push_back(shuffle_step(word));
        @(negedge i_clk);
        s_axis_tvalid = 1'b0;
    endtask

    task automatic wait_drained();
        while (perm_expect_q.size() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    // Length writes only land while no step is in flight.
    task automatic write_length(input logic [LEN_W-1:0] len);
        wait_drained();
        i_cfg_we    = 1'b1;
        i_cfg_wdata = len;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
        shuf_len = len;
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Reset length (1024) and word extremes; run left open for the next test.
    task automatic test_default_length();
        set_traffic(TRAFFIC_FREE);
        send_word('0);
        send_word('1);
        send_word(32'h8000_0000);
        send_word(32'd1023);
        send_word(32'h5555_5555);
    endtask

    // Length 1 and length 0: every transfer is a whole run at position 0.
    // The first write also abandons the open run from the reset length.
    task automatic test_unit_length();
        write_length(LEN_W'(1));
        send_word('0);
        send_word('1);
        send_word(pick_word());
        write_length('0);
        send_word('1);
        send_word(pick_word());
    endtask

    // Above-depth length saturates, then shrinking below the step restarts the run.
    task automatic test_saturated_length();
        write_length('1);
        send_word('1);
        send_word('0);
        send_word(pick_word());
        write_length(LEN_W'(2));
        repeat (3) send_word(pick_word());
    endtask

    // Growing the length mid-run keeps the run going to the new end.
    task automatic test_length_growth();
        write_length(LEN_W'(4));
        send_word('1);
        send_word(pick_word());
        write_length(LEN_W'(9));
        repeat (7) send_word(pick_word());
    endtask

    // A long stretch of a run at the deepest table; swap partners reach up to 1023.
    // The next length write abandons it.
    task automatic test_max_length_run();
        write_length(LEN_W'(MAX_LENGTH_DEF));
        set_traffic(TRAFFIC_SINK_STALLS);
        repeat (200) send_word(pick_word());
    endtask

    // Enough single-entry runs to wrap the run tag and trigger its clearing pass,
    // then short runs to see the table come back clean.
    task automatic test_tag_wrap();
        write_length(LEN_W'(1));
        set_traffic(TRAFFIC_SRC_GAPS);
        repeat (260) send_word(pick_word());
        write_length(LEN_W'(3));
        set_traffic(TRAFFIC_BOTH);
        repeat (30) send_word(pick_word());
    endtask

    // Random lengths, mostly complete short runs, some cut off by the next write.
    task automatic test_random_runs();
        int unsigned sent;
        int unsigned r;
        int unsigned n;
        int unsigned burst;
        logic [LEN_W-1:0] len;
        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            r = $urandom_range(99);
            if (r < 65)      len = LEN_W'($urandom_range(1, 12));
            else if (r < 88) len = LEN_W'($urandom_range(13, 64));
            else if (r < 94) len = LEN_W'($urandom_range(65, 300));
            else if (r < 96) len = '0;
            else             len = LEN_W'($urandom_range(MAX_LENGTH_DEF, 2047));
            write_length(len);
            set_traffic(t_traffic'((sent / 120) % 4));
            n = effective_len(len);
            if (n <= 64) begin
                burst = n * $urandom_range(1, 3);
                if ($urandom_range(99) < 30) burst += $urandom_range(0, n - 1);
            end else begin
                burst = $urandom_range(5, 40);
            end
            repeat (burst) send_word(pick_word());
            sent += burst;
        end
    endtask

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------
    initial begin
        i_rst_n       = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_wdata   = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        repeat (2) @(negedge i_clk);
        i_rst_n = 1'b1;

        test_default_length();
        test_unit_length();
        test_saturated_length();
        test_length_growth();
        test_max_length_run();
        test_tag_wrap();
        test_random_runs();

        wait_drained();
        if (mismatch_cnt == 0)
            $display("random_permutation_shuffle_unit: match");
        else
            $display("random_permutation_shuffle_unit: mismatch");
        $finish;
    end

endmodule
